@@ src/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache controller.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

    // Default geometry limits.
    localparam int DEF_MAX_SETS   = 256;
    localparam int DEF_MAX_WAYS   = 8;
    localparam int DEF_ADDR_WIDTH = 32;

    // Width of the configuration port fields.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 8;

    // Command codes.
    localparam logic [1:0] CMD_READ       = 2'd0;
    localparam logic [1:0] CMD_WRITE      = 2'd1;
    localparam logic [1:0] CMD_INVALIDATE = 2'd2;

    // Action codes.
    localparam logic [1:0] ACT_STATUS     = 2'd0;
    localparam logic [1:0] ACT_READ_NEXT  = 2'd1;
    localparam logic [1:0] ACT_WRITE_NEXT = 2'd2;
    localparam logic [1:0] ACT_INV_UPPER  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINE_BYTES = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SET_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAYS       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_BACK = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_ALLOC = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UPPER      = 3'd5;

    // Request beat.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] address;
    } req_item_t;

    // Response beat.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] target_address;
        logic        hit;
        logic        last;
    } rsp_item_t;

endpackage

`default_nettype wire

@@ src/salc_ram.sv @@
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/set_assoc_lru_cache_controller_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_controller_unit
// Set-associative tag cache with true LRU replacement, write-back or
// write-through, write-allocate or no-allocate.
// ----------------------------------------------------------------------------
//  Channel | Signals                        | Direction | Meaning
//  --------+--------------------------------+-----------+-------------------
//  req     | req_valid, req_stall, req      | in        | command beats
//  rsp     | rsp_valid, rsp_stall, rsp      | out       | action/status beats
//  cfg     | cfg_valid, cfg_ready, index/data| in       | register writes
//
// A command is accepted in S_IDLE, which starts the set read from the set RAM;
// S_UPDATE does compare, LRU update and write back; S_EMIT then sends its
// result beats (1 to 4), one beat per cycle while rsp is not stalled.
// Reset clears all set-valid flags at once; a set never written reads as
// invalid ways with rank equal to way number. Geometry and write policy
// writes do the same. rsp_stall only holds the current beat; req is stalled
// until the last beat of a command is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_controller_unit #(
    parameter int MAX_SETS   = salc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS   = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_stall,
    input  wire salc_pkg::req_item_t                   req,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_stall,
    output salc_pkg::rsp_item_t                        rsp,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [salc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [salc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int AW        = ADDR_WIDTH;
    localparam int SBM       = $clog2(MAX_SETS + 1) - 1;
    localparam int IW        = (SBM > 0) ? SBM : 1;
    localparam int SET_DEPTH = 1 << SBM;
    localparam int RW        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW       = $clog2(MAX_WAYS + 1);
    localparam int EW        = AW + 2 + RW;
    localparam int MW        = MAX_WAYS * EW;
    localparam int LIST      = 5;
    localparam int LW        = $clog2(LIST);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;

    // Configuration registers.
    logic [2:0] line_bytes_reg;
    logic [3:0] set_count_reg;
    logic [3:0] ways_reg;
    logic       write_back_reg;
    logic       write_alloc_reg;
    logic       upper_reg;

    logic [1:0]           state_reg, state_next;
    logic [SET_DEPTH-1:0] set_valid_reg;

    // Command context latched at accept.
    logic [1:0]    cmd_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] tag_reg;
    logic [IW-1:0] set_reg;
    logic [2:0]    ob_reg;
    logic [4:0]    shamt_reg;
    logic [WCW-1:0] ways_eff_reg;

    // Result list.
    salc_pkg::rsp_item_t lst_reg [LIST];
    logic [LW-1:0]       idx_reg;
    logic [LW-1:0]       last_idx_reg;

    logic [MW-1:0] rd_data;
    logic [MW-1:0] wr_data;
    logic          ram_we;

    logic          accept;
    logic [AW-1:0] in_addr;
    logic [3:0]    sb;
    logic [4:0]    shamt;
    logic [IW-1:0] in_set;
    logic [AW-1:0] in_tag;

    salc_pkg::rsp_item_t lst [LIST];
    logic [LW-1:0]       lst_cnt;

    assign cfg_ready = 1'b1;
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_EMIT);
    assign rsp       = lst_reg[idx_reg];
    assign ram_we    = (state_reg == S_UPDATE);

    // Address split with the effective geometry.
    always_comb
    begin
        in_addr = req.address[AW-1:0];
        sb      = (int'(set_count_reg) > SBM) ? 4'(SBM) : set_count_reg;
        shamt   = 5'(line_bytes_reg) + 5'(sb);
        in_set  = IW'((in_addr >> line_bytes_reg) & ((AW'(1) << sb) - AW'(1)));
        in_tag  = in_addr >> shamt;
    end

    salc_ram #(
        .WIDTH (MW),
        .DEPTH (SET_DEPTH)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (set_reg),
        .wdata (wr_data),
        .re    (accept),
        .raddr (in_set),
        .rdata (rd_data)
    );

    // Lookup, victim choice, LRU update and result list for one command.
    always_comb
    begin
        logic [AW-1:0] tg [MAX_WAYS];
        logic          v  [MAX_WAYS];
        logic          d  [MAX_WAYS];
        logic [RW-1:0] rk [MAX_WAYS];
        logic [EW-1:0] e;
        logic          hit;
        logic          found_inv;
        logic          hit_eff;
        int            best;
        int            hway;
        int            vic;
        int            mway;
        logic          do_mru;
        logic [RW-1:0] r;
        logic [AW-1:0] vline;
        logic [AW-1:0] iline;
        logic          alloc;
        logic          evict_valid;

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            e = rd_data[i*EW +: EW];
            if (set_valid_reg[set_reg])
            begin
                tg[i] = e[AW-1:0];
                v[i]  = e[AW];
                d[i]  = e[AW+1];
                rk[i] = e[AW+2 +: RW];
            end
            else
            begin
                tg[i] = e[AW-1:0];
                v[i]  = 1'b0;
                d[i]  = 1'b0;
                rk[i] = RW'(i);
            end
        end

        // Lowest valid way whose tag matches.
        hit  = 1'b0;
        hway = 0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(ways_eff_reg) && !hit && v[i] && tg[i] == tag_reg)
            begin
                hit  = 1'b1;
                hway = i;
            end
        end

        // Victim: invalid way of highest rank, else way of highest rank.
        found_inv = 1'b0;
        best      = -1;
        vic       = 0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (i < int'(ways_eff_reg) && !v[i] && int'(rk[i]) > best)
            begin
                best      = int'(rk[i]);
                vic       = i;
                found_inv = 1'b1;
            end
        end
        if (!found_inv)
        begin
            best = -1;
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (i < int'(ways_eff_reg) && int'(rk[i]) > best)
                begin
                    best = int'(rk[i]);
                    vic  = i;
                end
            end
        end

        vline = (tg[vic] << shamt_reg) | (AW'(set_reg) << ob_reg);
        iline = addr_reg & ~((AW'(1) << ob_reg) - AW'(1));
        evict_valid = !found_inv;

        for (int i = 0; i < LIST; i++)
        begin
            lst[i] = '{salc_pkg::ACT_STATUS, 32'(addr_reg), 1'b0, 1'b0};
        end
        lst_cnt = '0;
        hit_eff = hit;
        do_mru  = 1'b0;
        mway    = hway;
        alloc   = 1'b0;

        case (cmd_reg)
            salc_pkg::CMD_READ:
            begin
                do_mru = 1'b1;
                alloc  = !hit;
            end
            salc_pkg::CMD_WRITE:
            begin
                if (hit)
                begin
                    do_mru = 1'b1;
                    if (write_back_reg)
                    begin
                        d[hway] = 1'b1;
                    end
                end
                else if (!write_alloc_reg)
                begin
                    lst[lst_cnt] = '{salc_pkg::ACT_WRITE_NEXT, 32'(addr_reg), 1'b0, 1'b0};
                    lst_cnt = lst_cnt + 1'b1;
                end
                else
                begin
                    do_mru = 1'b1;
                    alloc  = 1'b1;
                end
            end
            salc_pkg::CMD_INVALIDATE:
            begin
                if (upper_reg)
                begin
                    lst[lst_cnt] = '{salc_pkg::ACT_INV_UPPER, 32'(iline), 1'b0, 1'b0};
                    lst_cnt = lst_cnt + 1'b1;
                end
                if (hit)
                begin
                    v[hway] = 1'b0;
                    if (d[hway])
                    begin
                        lst[lst_cnt] = '{salc_pkg::ACT_WRITE_NEXT, 32'(iline), 1'b0, 1'b0};
                        lst_cnt = lst_cnt + 1'b1;
                    end
                    d[hway] = 1'b0;
                end
            end
            default:
            begin
                hit_eff = 1'b0;
            end
        endcase

        // Eviction and install of a missed line.
        if (alloc)
        begin
            mway = vic;
            if (evict_valid)
            begin
                if (upper_reg)
                begin
                    lst[lst_cnt] = '{salc_pkg::ACT_INV_UPPER, 32'(vline), 1'b0, 1'b0};
                    lst_cnt = lst_cnt + 1'b1;
                end
                if (d[vic])
                begin
                    lst[lst_cnt] = '{salc_pkg::ACT_WRITE_NEXT, 32'(vline), 1'b0, 1'b0};
                    lst_cnt = lst_cnt + 1'b1;
                end
            end
            tg[vic] = tag_reg;
            v[vic]  = 1'b1;
            d[vic]  = (cmd_reg == salc_pkg::CMD_WRITE) && write_back_reg;
            lst[lst_cnt] = '{salc_pkg::ACT_READ_NEXT, 32'(addr_reg), 1'b0, 1'b0};
            lst_cnt = lst_cnt + 1'b1;
        end

        // Write-through forward after a hit or an allocating miss.
        if (cmd_reg == salc_pkg::CMD_WRITE && !write_back_reg && (hit || write_alloc_reg))
        begin
            lst[lst_cnt] = '{salc_pkg::ACT_WRITE_NEXT, 32'(addr_reg), 1'b0, 1'b0};
            lst_cnt = lst_cnt + 1'b1;
        end

        // Make the touched way most recently used.
        r = rk[mway];
        if (do_mru)
        begin
            for (int i = 0; i < MAX_WAYS; i++)
            begin
                if (i < int'(ways_eff_reg) && rk[i] < r)
                begin
                    rk[i] = rk[i] + 1'b1;
                end
            end
            rk[mway] = '0;
        end

        lst[lst_cnt] = '{salc_pkg::ACT_STATUS, 32'(addr_reg), hit_eff, 1'b1};

        for (int i = 0; i < MAX_WAYS; i++)
        begin
            wr_data[i*EW +: EW] = {rk[i], d[i], v[i], tg[i]};
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_stall && idx_reg == last_idx_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            set_valid_reg   <= '0;
            idx_reg         <= '0;
            last_idx_reg    <= '0;
            line_bytes_reg  <= 3'd4;
            set_count_reg   <= 4'd4;
            ways_reg        <= 4'd2;
            write_back_reg  <= 1'b1;
            write_alloc_reg <= 1'b1;
            upper_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_UPDATE)
            begin
                set_valid_reg[set_reg] <= 1'b1;
                idx_reg                <= '0;
                last_idx_reg           <= lst_cnt;
            end
            else if (state_reg == S_EMIT && !rsp_stall)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    salc_pkg::REG_LINE_BYTES:
                    begin
                        line_bytes_reg <= cfg_data[2:0];
                        set_valid_reg  <= '0;
                    end
                    salc_pkg::REG_SET_COUNT:
                    begin
                        set_count_reg <= cfg_data[3:0];
                        set_valid_reg <= '0;
                    end
                    salc_pkg::REG_WAYS:
                    begin
                        ways_reg      <= cfg_data[3:0];
                        set_valid_reg <= '0;
                    end
                    salc_pkg::REG_WRITE_BACK:
                    begin
                        write_back_reg <= cfg_data[0];
                        set_valid_reg  <= '0;
                    end
                    salc_pkg::REG_WRITE_ALLOC:
                    begin
                        write_alloc_reg <= cfg_data[0];
                        set_valid_reg   <= '0;
                    end
                    salc_pkg::REG_UPPER:
                    begin
                        upper_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Command context and result list.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.command;
            addr_reg  <= in_addr;
            tag_reg   <= in_tag;
            set_reg   <= in_set;
            ob_reg    <= line_bytes_reg;
            shamt_reg <= shamt;
            if (ways_reg == 4'd0)
            begin
                ways_eff_reg <= WCW'(1);
            end
            else if (int'(ways_reg) > MAX_WAYS)
            begin
                ways_eff_reg <= WCW'(MAX_WAYS);
            end
            else
            begin
                ways_eff_reg <= WCW'(ways_reg);
            end
        end
        if (state_reg == S_UPDATE)
        begin
            for (int i = 0; i < LIST; i++)
            begin
                lst_reg[i] <= lst[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache controller. A tag and
// LRU predictor follows every accepted command beat and queues the action and
// status beats the cache must emit; a monitor compares each response beat
// field by field. Geometry and policy are changed between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam int SHADOW_SETS = 256;
    localparam int SHADOW_WAYS = 8;
    localparam int WDOG_LIMIT  = 5000;

    // Command code outside the defined set, and register indexes past the list.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [salc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [salc_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 req_valid;
    logic                                 req_stall;
    salc_pkg::req_item_t                  req;
    logic                                 rsp_valid;
    logic                                 rsp_stall;
    salc_pkg::rsp_item_t                  rsp;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [salc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [salc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    set_assoc_lru_cache_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the cache tags and registers.
    logic [31:0] tag_mem [SHADOW_SETS*SHADOW_WAYS];
    bit          line_vld[SHADOW_SETS*SHADOW_WAYS];
    bit          line_drt[SHADOW_SETS*SHADOW_WAYS];
    int          lru_pos [SHADOW_SETS*SHADOW_WAYS];
    int          line_log2;
    int          set_log2;
    int          way_cfg;
    bit          wback;
    bit          walloc;
    bit          upper;

    salc_pkg::req_item_t pending_cmds[$];
    salc_pkg::rsp_item_t expected_beats[$];
    logic [31:0] tag_pool[4];
    int          error_count;
    int          cmds_taken;
    int          idle_cycles;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          long_hold_done;
    int          cyc;

    // Clock.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mismatch reporting.
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_lines();
        for (int i = 0; i < SHADOW_SETS*SHADOW_WAYS; i++)
        begin
            tag_mem[i]  = '0;
            line_vld[i] = 1'b0;
            line_drt[i] = 1'b0;
            lru_pos[i]  = i % SHADOW_WAYS;
        end
    endfunction

    function automatic int eff_set_bits();
        int s;
        s = set_log2;
        while (s > 0 && (1 << s) > SHADOW_SETS)
            s--;
        return s;
    endfunction

    function automatic int eff_ways();
        if (way_cfg < 1)
            return 1;
        if (way_cfg > SHADOW_WAYS)
            return SHADOW_WAYS;
        return way_cfg;
    endfunction

    function automatic void queue_beat(logic [1:0] act, logic [31:0] tgt, logic h,
                                       logic lst);
        salc_pkg::rsp_item_t b;
        b.action         = act;
        b.target_address = tgt;
        b.hit            = h;
        b.last           = lst;
        expected_beats.push_back(b);
    endfunction

    function automatic void promote_way(int base, int way, int w);
        int r;
        r = lru_pos[base+way];
        for (int i = 0; i < w; i++)
            if (lru_pos[base+i] < r)
                lru_pos[base+i]++;
        lru_pos[base+way] = 0;
    endfunction

    // Choose the replacement way and queue any eviction beats.
    function automatic int pick_victim(int base, int w, int set, int ob, int sb);
        int best;
        int pick;
        logic [31:0] line;
        best = -1;
        pick = 0;
        for (int i = 0; i < w; i++)
            if (!line_vld[base+i] && lru_pos[base+i] > best)
            begin
                best = lru_pos[base+i];
                pick = i;
            end
        if (best >= 0)
            return pick;
        for (int i = 0; i < w; i++)
            if (lru_pos[base+i] > best)
            begin
                best = lru_pos[base+i];
                pick = i;
            end
        line = (tag_mem[base+pick] << (ob + sb)) | (32'(set) << ob);
        if (upper)
            queue_beat(salc_pkg::ACT_INV_UPPER, line, 1'b0, 1'b0);
        if (line_drt[base+pick])
            queue_beat(salc_pkg::ACT_WRITE_NEXT, line, 1'b0, 1'b0);
        line_vld[base+pick] = 1'b0;
        line_drt[base+pick] = 1'b0;
        return pick;
    endfunction

    // Predict the beats of one command and update the shadow state.
    function automatic void predict_cache(salc_pkg::req_item_t it);
        int ob, sb, w, set, base, way;
        bit found;
        logic [31:0] a, tag, line;
        a     = it.address;
        ob    = line_log2;
        sb    = eff_set_bits();
        w     = eff_ways();
        set   = int'((a >> ob) & ((32'd1 << sb) - 32'd1));
        tag   = a >> (ob + sb);
        base  = set * SHADOW_WAYS;
        way   = 0;
        found = 1'b0;
        for (int i = 0; i < w; i++)
            if (!found && line_vld[base+i] && tag_mem[base+i] == tag)
            begin
                way   = i;
                found = 1'b1;
            end
        if (it.command == salc_pkg::CMD_READ)
        begin
            if (!found)
            begin
                way = pick_victim(base, w, set, ob, sb);
                tag_mem[base+way]  = tag;
                line_vld[base+way] = 1'b1;
                line_drt[base+way] = 1'b0;
            end
            promote_way(base, way, w);
            if (!found)
                queue_beat(salc_pkg::ACT_READ_NEXT, a, 1'b0, 1'b0);
        end
        else if (it.command == salc_pkg::CMD_WRITE)
        begin
            if (found)
            begin
                promote_way(base, way, w);
                if (wback)
                    line_drt[base+way] = 1'b1;
                else
                    queue_beat(salc_pkg::ACT_WRITE_NEXT, a, 1'b0, 1'b0);
            end
            else if (!walloc)
                queue_beat(salc_pkg::ACT_WRITE_NEXT, a, 1'b0, 1'b0);
            else
            begin
                way = pick_victim(base, w, set, ob, sb);
                tag_mem[base+way]  = tag;
                line_vld[base+way] = 1'b1;
                line_drt[base+way] = wback;
                promote_way(base, way, w);
                queue_beat(salc_pkg::ACT_READ_NEXT, a, 1'b0, 1'b0);
                if (!wback)
                    queue_beat(salc_pkg::ACT_WRITE_NEXT, a, 1'b0, 1'b0);
            end
        end
        else if (it.command == salc_pkg::CMD_INVALIDATE)
        begin
            line = a & ~((32'd1 << ob) - 32'd1);
            if (upper)
                queue_beat(salc_pkg::ACT_INV_UPPER, line, 1'b0, 1'b0);
            if (found)
            begin
                line_vld[base+way] = 1'b0;
                if (line_drt[base+way])
                    queue_beat(salc_pkg::ACT_WRITE_NEXT, line, 1'b0, 1'b0);
                line_drt[base+way] = 1'b0;
            end
        end
        else
            found = 1'b0;
        queue_beat(salc_pkg::ACT_STATUS, a, found, 1'b1);
    endfunction

    function automatic void apply_register(logic [salc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                           logic [salc_pkg::CFG_DATA_WIDTH-1:0] val);
        case (idx)
            salc_pkg::REG_LINE_BYTES:  begin line_log2 = val & 7;  clear_lines(); end
            salc_pkg::REG_SET_COUNT:   begin set_log2  = val & 15; clear_lines(); end
            salc_pkg::REG_WAYS:        begin way_cfg   = val & 15; clear_lines(); end
            salc_pkg::REG_WRITE_BACK:  begin wback     = val[0];   clear_lines(); end
            salc_pkg::REG_WRITE_ALLOC: begin walloc    = val[0];   clear_lines(); end
            salc_pkg::REG_UPPER:       upper = val[0];
            default: ;
        endcase
    endfunction

    // Command driver: bursts of beats separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid  <= 1'b0;
            req        <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                req       <= pending_cmds.pop_front();
                req_valid <= 1'b1;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Response stall pattern, with one long hold once traffic is flowing.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall      <= 1'b0;
            hold_left      = 0;
            long_hold_done = 1'b0;
            cyc            = 0;
        end
        else
        begin
            cyc++;
            if (!long_hold_done && cmds_taken >= 40)
            begin
                long_hold_done = 1'b1;
                hold_left      = 120;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if ((cyc / 200) % 3 == 0)
                rsp_stall <= 1'b0;
            else
                rsp_stall <= ($urandom_range(0, 99) < ((cyc / 200) % 3) * 30);
        end
    end

    // Prediction on accepted commands and checking of response beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                predict_cache(req);
                cmds_taken++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_beats.size() == 0)
                    report_error($sformatf("unexpected beat act=%0d addr=%h",
                                           rsp.action, rsp.target_address));
                else
                begin
                    salc_pkg::rsp_item_t e;
                    e = expected_beats.pop_front();
                    if (rsp.action !== e.action)
                        report_error($sformatf("action %0d, expected %0d",
                                               rsp.action, e.action));
                    if (rsp.target_address !== e.target_address)
                        report_error($sformatf("target %h, expected %h",
                                               rsp.target_address, e.target_address));
                    if (rsp.hit !== e.hit)
                        report_error($sformatf("hit %0b, expected %0b", rsp.hit, e.hit));
                    if (rsp.last !== e.last)
                        report_error($sformatf("last %0b, expected %0b", rsp.last, e.last));
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_register(input logic [salc_pkg::CFG_INDEX_WIDTH-1:0] idx,
                                  input logic [salc_pkg::CFG_DATA_WIDTH-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every command is taken and every beat has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_cmds.size() > 0 || req_valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic void push_cmd(logic [1:0] c, logic [31:0] a);
        salc_pkg::req_item_t it;
        it.command = c;
        it.address = a;
        pending_cmds.push_back(it);
    endfunction

    // Address from a few tags and sets so that hits and evictions are common.
    function automatic logic [31:0] pick_address();
        int ob, sb;
        logic [31:0] set, off;
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        ob  = line_log2;
        sb  = eff_set_bits();
        set = $urandom_range(0, 2) & ((32'd1 << sb) - 32'd1);
        off = $urandom & ((32'd1 << ob) - 32'd1);
        return (tag_pool[$urandom_range(0, 3)] << (ob + sb)) | (set << ob) | off;
    endfunction

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < 4; i++)
            tag_pool[i] = (i < 2) ? 32'(i) : $urandom;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                push_cmd(salc_pkg::CMD_READ, pick_address());
            else if (r < 80)
                push_cmd(salc_pkg::CMD_WRITE, pick_address());
            else if (r < 95)
                push_cmd(salc_pkg::CMD_INVALIDATE, pick_address());
            else
                push_cmd(CMD_UNUSED, pick_address());
        end
        wait_drained();
    endtask

    initial
    begin
        error_count = 0;
        cmds_taken  = 0;
        idle_cycles = 0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        line_log2   = 4;
        set_log2    = 4;
        way_cfg     = 2;
        wback       = 1'b1;
        walloc      = 1'b1;
        upper       = 1'b0;
        clear_lines();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: hits, misses, dirty eviction, invalidates, unused command.
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0000);
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0004);
        push_cmd(salc_pkg::CMD_WRITE,      32'h0000_0008);
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0100);
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0200);
        push_cmd(salc_pkg::CMD_WRITE,      32'h0000_0300);
        push_cmd(salc_pkg::CMD_INVALIDATE, 32'h0000_0304);
        push_cmd(salc_pkg::CMD_INVALIDATE, 32'h0000_0304);
        push_cmd(salc_pkg::CMD_WRITE,      32'hFFFF_FFFF);
        push_cmd(salc_pkg::CMD_READ,       32'hFFFF_FFF0);
        push_cmd(salc_pkg::CMD_INVALIDATE, 32'hFFFF_FFFF);
        push_cmd(CMD_UNUSED,               32'hFFFF_FFFF);
        push_cmd(CMD_UNUSED,               32'h0000_0000);
        wait_drained();
        write_register(salc_pkg::REG_UPPER, 8'd1);
        push_cmd(salc_pkg::CMD_WRITE,      32'h0000_0110);
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0210);
        push_cmd(salc_pkg::CMD_READ,       32'h0000_0310);
        push_cmd(salc_pkg::CMD_INVALIDATE, 32'h0000_0010);
        push_cmd(salc_pkg::CMD_INVALIDATE, 32'h0000_0310);
        run_random(60);

        // Write-through, no allocate, one way, tiny lines and a single set.
        write_register(salc_pkg::REG_LINE_BYTES, 8'd2);
        write_register(salc_pkg::REG_SET_COUNT, 8'd0);
        write_register(salc_pkg::REG_WAYS, 8'd1);
        write_register(salc_pkg::REG_WRITE_BACK, 8'd0);
        write_register(salc_pkg::REG_WRITE_ALLOC, 8'd0);
        run_random(55);

        // Largest geometry, write-back with allocate.
        write_register(salc_pkg::REG_LINE_BYTES, 8'd7);
        write_register(salc_pkg::REG_SET_COUNT, 8'd8);
        write_register(salc_pkg::REG_WAYS, 8'd8);
        write_register(salc_pkg::REG_WRITE_BACK, 8'd1);
        write_register(salc_pkg::REG_WRITE_ALLOC, 8'd1);
        run_random(55);

        // Out-of-range values, write-through with allocate, no upper level.
        write_register(salc_pkg::REG_UPPER, 8'd0);
        write_register(salc_pkg::REG_LINE_BYTES, 8'hFF);
        write_register(salc_pkg::REG_SET_COUNT, 8'hFF);
        write_register(salc_pkg::REG_WAYS, 8'hFF);
        write_register(salc_pkg::REG_WRITE_BACK, 8'hFE);
        write_register(REG_SPARE_LO, 8'h55);
        write_register(REG_SPARE_HI, 8'hAA);
        run_random(55);

        // Zero ways, byte lines, upper level again.
        write_register(salc_pkg::REG_WAYS, 8'd0);
        write_register(salc_pkg::REG_LINE_BYTES, 8'd0);
        write_register(salc_pkg::REG_SET_COUNT, 8'd2);
        write_register(salc_pkg::REG_UPPER, 8'hFF);
        run_random(40);

        // Two-byte lines, four ways, write-back without allocate.
        write_register(salc_pkg::REG_LINE_BYTES, 8'd1);
        write_register(salc_pkg::REG_WAYS, 8'd4);
        write_register(salc_pkg::REG_WRITE_BACK, 8'd1);
        write_register(salc_pkg::REG_WRITE_ALLOC, 8'd0);
        run_random(45);

        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
